>>> src/dtq_pkg.sv
// dtq_pkg: shared types and constants for the deadline timer queue
// holds operation and status codes, controller states and the command/status structs
// no dependencies
`default_nettype none

package dtq_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int SLOTS_MAX      = 32;
  localparam logic [31:0] ROLLOVER_RESET = 32'd3600000;  // one hour in ms

  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_CANCEL  = 3'd1,
    FN_REFRESH = 3'd2,
    FN_RESET   = 3'd3,
    FN_POLL    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_RMW,
    S_EXP,
    S_SEL,
    S_UPD,
    S_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SCAN_EXP,
    SCAN_SEL,
    SCAN_FIN
  } scan_mode_t;

  // one table entry
  typedef struct packed {
    logic        flag;
    logic [31:0] per;
    logic [47:0] dl;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       dispatch;
    logic       rmw;
    logic       scan_clr;
    logic       scan_en;
    scan_mode_t mode;
    logic       commit;
    logic       emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       valid;
    logic       empty;
    logic       scan_done;
    logic       found;
    logic       last;
  } stat_t;

endpackage

`default_nettype wire

>>> src/dtq_ctrl.sv
// dtq_ctrl: sequencer for the deadline timer queue
// steps each item through dispatch, table scans and result emission
// depends on dtq_pkg
`default_nettype none

module dtq_ctrl import dtq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DISP;
      end
      S_DISP: begin
        if ((stat.func == FN_REFRESH || stat.func == FN_RESET) && stat.valid) begin
          state_next = S_RMW;
        end else if (stat.func == FN_POLL && !stat.empty) begin
          state_next = S_EXP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RMW: state_next = S_FIN;
      S_EXP: begin
        if (stat.scan_done) state_next = S_SEL;
      end
      S_SEL: begin
        if (stat.scan_done) state_next = stat.found ? S_UPD : S_FIN;
      end
      S_UPD: state_next = S_SEL;
      S_FIN: begin
        if (stat.scan_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    cmd.mode = SCAN_FIN;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.load = start;
      S_DISP: begin
        cmd.dispatch = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_RMW: begin
        cmd.rmw      = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_EXP: begin
        cmd.scan_en  = 1'b1;
        cmd.mode     = SCAN_EXP;
        cmd.scan_clr = stat.scan_done;
      end
      S_SEL: begin
        cmd.scan_en  = 1'b1;
        cmd.mode     = SCAN_SEL;
        cmd.scan_clr = stat.scan_done && !stat.found;
      end
      S_UPD: begin
        cmd.commit   = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_FIN: begin
        cmd.scan_en = 1'b1;
        cmd.mode    = SCAN_FIN;
      end
      S_EMIT: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/dtq_dp.sv
// dtq_dp: datapath of the deadline timer queue
// slot table memory, valid bits, scan unit, expiry list and result fields
// depends on dtq_pkg
`default_nettype none

module dtq_dp import dtq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic [31:0] rollover_window,
  input  wire logic [2:0]  func,
  input  wire logic [4:0]  slot,
  input  wire logic [31:0] interval_ms,
  input  wire logic        recurring,
  input  wire logic        rebase_now,
  input  wire logic [47:0] now_ms,
  output logic             out_valid,
  output logic [1:0]       status,
  output logic [4:0]       slot_out,
  output logic             at_front,
  output logic             last,
  output logic [47:0]      next_deadline,
  output logic [5:0]       active_count
);

  localparam int NSLOTS = (CAPACITY < SLOTS_MAX) ? CAPACITY : SLOTS_MAX;
  localparam int IW     = $clog2(NSLOTS);

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  // latched item
  logic [2:0]  func_q;
  logic [4:0]  slot_q;
  logic [31:0] ms_q;
  logic        rec_q;
  logic        fnow_q;
  logic [47:0] now_q;

  logic [NSLOTS-1:0] active;
  logic [NSLOTS-1:0] expd;
  entry_t            mem [NSLOTS];
  entry_t            rdata;
  logic [47:0]       lpt;
  logic              roll;

  logic [IW:0]   scan_cnt;
  logic          rvalid;
  logic [IW-1:0] ridx;
  logic          found;
  logic [47:0]   best_dl;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_per;
  logic          best_flag;
  logic [IW-1:0] min_idx;
  logic [IW:0]   cnt_act;

  logic [IW-1:0] list [NSLOTS];
  logic [IW:0]   n_q;
  logic [IW:0]   emit_idx;
  status_t       res_status;
  logic [IW-1:0] res_slot;
  logic          front_chk;

  logic [IW-1:0] sidx;
  logic          valid;
  logic          full;
  logic [IW-1:0] free_idx;
  logic          issuing;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [47:0]   base;
  logic          poll_list;

  assign sidx  = slot_q[IW-1:0];
  assign valid = ({1'b0, slot_q} < 6'(NSLOTS)) && active[sidx];
  assign full  = &active;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      if (!active[i]) free_idx = IW'(i);
    end
  end

  assign issuing = cmd.scan_en && (scan_cnt < (IW+1)'(NSLOTS));
  assign raddr   = cmd.scan_en ? scan_cnt[IW-1:0] : sidx;

  // old start for reset (or now_ms when rebase_now is set), clamped at zero
  always_comb begin
    if (fnow_q) begin
      base = now_q;
    end else if (rdata.dl >= {16'd0, rdata.per}) begin
      base = rdata.dl - {16'd0, rdata.per};
    end else begin
      base = '0;
    end
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = sidx;
    wdata = rdata;
    if (cmd.dispatch && func_q == FN_ADD && !full) begin
      we    = 1'b1;
      waddr = free_idx;
      wdata = '{flag: rec_q, per: ms_q, dl: sat_add(now_q, {16'd0, ms_q})};
    end else if (cmd.rmw) begin
      we = 1'b1;
      if (func_q == FN_REFRESH) begin
        wdata.dl = sat_add(now_q, {16'd0, rdata.per});
      end else begin
        wdata.dl  = sat_add(base, {16'd0, ms_q});
        wdata.per = ms_q;
      end
    end else if (cmd.commit && best_flag) begin
      we    = 1'b1;
      waddr = best_idx;
      wdata = '{flag: 1'b1, per: best_per, dl: sat_add(now_q, {16'd0, best_per})};
    end
  end

  // slot table memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      slot_q <= slot;
      ms_q   <= interval_ms;
      rec_q  <= recurring;
      fnow_q <= rebase_now;
      now_q  <= now_ms;
    end
  end

  // valid bits and poll time
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      lpt    <= '0;
    end else begin
      if (cmd.dispatch) begin
        if (func_q == FN_ADD && !full) active[free_idx] <= 1'b1;
        if (func_q == FN_CANCEL && valid) active[sidx] <= 1'b0;
        if (func_q == FN_POLL && !full && active == '0) begin
          lpt <= lpt;
        end else if (func_q == FN_POLL) begin
          lpt <= now_q;
        end
      end
      if (cmd.commit && !best_flag) active[best_idx] <= 1'b0;
    end
  end

  // dispatch results and expiry list
  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      n_q       <= '0;
      emit_idx  <= '0;
      front_chk <= 1'b0;
      res_slot  <= '0;
      roll      <= (now_q < lpt) && ((lpt - now_q) > {16'd0, rollover_window});
      case (func_q)
        FN_ADD: begin
          if (full) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_OK;
            res_slot   <= free_idx;
            front_chk  <= 1'b1;
          end
        end
        FN_CANCEL, FN_REFRESH, FN_RESET: begin
          res_status <= valid ? ST_OK : ST_INVALID;
          res_slot   <= sidx;
          front_chk  <= valid && (func_q == FN_RESET);
        end
        FN_POLL: res_status <= ST_NONE;
        default: res_status <= ST_INVALID;
      endcase
    end
    if (cmd.commit) begin
      list[n_q[IW-1:0]] <= best_idx;
      n_q               <= n_q + 1'b1;
    end
    if (cmd.emit) emit_idx <= emit_idx + 1'b1;
  end

  // scan unit, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      rvalid   <= 1'b0;
      found    <= 1'b0;
      expd     <= '0;
    end else if (cmd.scan_clr) begin
      scan_cnt <= '0;
      rvalid   <= 1'b0;
      found    <= 1'b0;
      best_dl  <= '1;
      cnt_act  <= '0;
      if (cmd.commit) expd[best_idx] <= 1'b0;
    end else if (cmd.scan_en) begin
      rvalid <= issuing;
      if (issuing) begin
        scan_cnt <= scan_cnt + 1'b1;
        ridx     <= scan_cnt[IW-1:0];
      end
      if (rvalid) begin
        case (cmd.mode)
          SCAN_EXP: expd[ridx] <= active[ridx] && (roll || rdata.dl <= now_q);
          SCAN_SEL: begin
            if (expd[ridx] && (!found || rdata.dl < best_dl)) begin
              found     <= 1'b1;
              best_dl   <= rdata.dl;
              best_idx  <= ridx;
              best_per  <= rdata.per;
              best_flag <= rdata.flag;
            end
          end
          SCAN_FIN: begin
            if (active[ridx]) begin
              cnt_act <= cnt_act + 1'b1;
              if (!found || rdata.dl < best_dl) begin
                found   <= 1'b1;
                best_dl <= rdata.dl;
                min_idx <= ridx;
              end
            end
          end
          default: found <= found;
        endcase
      end
    end
  end

  // status to controller
  assign poll_list = (func_q == FN_POLL) && (n_q != '0);
  always_comb begin
    stat.func      = func_q;
    stat.valid     = valid;
    stat.empty     = (active == '0);
    stat.scan_done = (scan_cnt == (IW+1)'(NSLOTS)) && !rvalid;
    stat.found     = found;
    stat.last      = poll_list ? (emit_idx == n_q - 1'b1) : 1'b1;
  end

  // result ports, slot_out carries a slot only for add and for poll entries
  assign out_valid     = cmd.emit;
  assign status        = poll_list ? ST_OK : res_status;
  assign slot_out      = poll_list ? 5'(list[emit_idx[IW-1:0]]) :
                         (func_q == FN_ADD) ? 5'(res_slot) : 5'd0;
  assign at_front      = !poll_list && front_chk && (min_idx == res_slot);
  assign last          = stat.last;
  assign next_deadline = best_dl;
  assign active_count  = 6'(cnt_act);

`ifndef SYNTHESIS
  a_commit_found: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> found) else $error("commit without a selected slot");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> cnt_act <= (IW+1)'(NSLOTS)) else $error("active count out of range");
  a_list_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && poll_list |-> emit_idx < n_q) else $error("emit past expiry list");
  a_rvalid_cnt: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> scan_cnt != '0) else $error("scan data without a read");
`endif

endmodule

`default_nettype wire

>>> src/deadline_timer_queue.sv
// deadline_timer_queue: top level, config register and controller/datapath
// depends on dtq_pkg, dtq_ctrl, dtq_dp
//
// channel   direction  handshake                  payload
// item in   input      start & !busy              func slot interval_ms recurring
//                                                  rebase_now now_ms
// result    output     out_valid, one cycle each  status slot_out at_front last next_deadline
//                                                  active_count
// config    apb        psel penable pwrite pready rollover_window at byte address 0
//
// an item holds busy through dispatch, a closing scan of the table and one emit per result,
// plus a read-modify-write step for refresh or reset of an active slot; a poll of a non-empty
// table adds an expiry scan, a pick scan and an update per expired slot and a closing pick,
// since each pick rescans the table through the single memory read port
// reset is synchronous and clears the valid bits, the poll time and the register
// results leave one per cycle and cannot be held off
`default_nettype none

module deadline_timer_queue import dtq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  func,
  input  wire logic [4:0]  slot,
  input  wire logic [31:0] interval_ms,
  input  wire logic        recurring,
  input  wire logic        rebase_now,
  input  wire logic [47:0] now_ms,
  output logic             out_valid,
  output logic [1:0]       status,
  output logic [4:0]       slot_out,
  output logic             at_front,
  output logic             last,
  output logic [47:0]      next_deadline,
  output logic [5:0]       active_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] rollover_window;
  cmd_t        cmd;
  stat_t       stat;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rollover_window <= ROLLOVER_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      rollover_window <= pwdata;
    end
  end
  assign prdata = paddr[2] ? 32'd0 : rollover_window;

  dtq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  dtq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .rollover_window (rollover_window),
    .func            (func),
    .slot            (slot),
    .interval_ms     (interval_ms),
    .recurring       (recurring),
    .rebase_now      (rebase_now),
    .now_ms          (now_ms),
    .out_valid       (out_valid),
    .status          (status),
    .slot_out        (slot_out),
    .at_front        (at_front),
    .last            (last),
    .next_deadline   (next_deadline),
    .active_count    (active_count)
  );

endmodule

`default_nettype wire

>>> tb/deadline_timer_queue_test.sv
// deadline_timer_queue_test: self-checking testbench for the deadline timer queue
// drives items and apb writes, predicts results in a scoreboard class
// depends on dtq_pkg and deadline_timer_queue
`timescale 1ns / 1ps

module deadline_timer_queue_test;
  import dtq_pkg::*;

  localparam int NSLOT = 32;
  localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  slot_out;
    logic        at_front;
    logic        last;
    logic [47:0] next_deadline;
    logic [5:0]  active_count;
  } timer_result_t;

  // timer table model and queue of pending results
  class timer_scoreboard;
    logic [31:0] window;
    bit          active[NSLOT];
    logic [47:0] dl[NSLOT];
    logic [31:0] per[NSLOT];
    bit          flag[NSLOT];
    logic [47:0] last_poll;
    timer_result_t pending[$];
    int errors;

    function new();
      window = ROLLOVER_RESET;
      last_poll = '0;
      errors = 0;
      foreach (active[i]) begin
        active[i] = 0;
        dl[i] = '0;
        per[i] = '0;
        flag[i] = 0;
      end
    endfunction

    function logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? ALL_ONES : s[47:0];
    endfunction

    function bit earlier(int a, int b);
      return dl[a] < dl[b] || (dl[a] == dl[b] && a < b);
    endfunction

    function bit heads_queue(int s);
      for (int t = 0; t < NSLOT; t++)
        if (t != s && active[t] && earlier(t, s)) return 0;
      return 1;
    endfunction

    function void push(logic [1:0] st, int sl, bit fr);
      timer_result_t r;
      r.status = st;
      r.slot_out = sl[4:0];
      r.at_front = fr;
      r.last = 0;
      r.next_deadline = '0;
      r.active_count = '0;
      pending.insert(pending.size(), r);
    endfunction

    // note an accepted item and queue its results
    function void note_item(logic [2:0] fn, logic [4:0] sl, logic [31:0] ms, bit rec,
                            bit fnow, logic [47:0] now);
      int first_idx, n, f, b;
      bit roll, any;
      bit exp[NSLOT];
      int order[$];
      logic [47:0] base, nd;
      int cnt;
      first_idx = pending.size();
      n = 1;
      if (fn == FN_ADD) begin
        f = -1;
        for (int s = 0; s < NSLOT; s++)
          if (!active[s] && f < 0) f = s;
        if (f < 0) push(ST_FULL, 0, 0);
        else begin
          active[f] = 1;
          per[f] = ms;
          flag[f] = rec;
          dl[f] = sat_sum(now, {16'd0, ms});
          push(ST_OK, f, heads_queue(f));
        end
      end else if (fn == FN_CANCEL || fn == FN_REFRESH || fn == FN_RESET) begin
        if (!active[sl]) push(ST_INVALID, 0, 0);
        else if (fn == FN_CANCEL) begin
          active[sl] = 0;
          push(ST_OK, 0, 0);
        end else if (fn == FN_REFRESH) begin
          dl[sl] = sat_sum(now, {16'd0, per[sl]});
          push(ST_OK, 0, 0);
        end else begin
          if (fnow) base = now;
          else base = (dl[sl] >= {16'd0, per[sl]}) ? dl[sl] - {16'd0, per[sl]} : '0;
          dl[sl] = sat_sum(base, {16'd0, ms});
          per[sl] = ms;
          push(ST_OK, 0, heads_queue(sl));
        end
      end else if (fn == FN_POLL) begin
        any = 0;
        foreach (active[s]) if (active[s]) any = 1;
        if (!any) push(ST_NONE, 0, 0);
        else begin
          roll = now < last_poll && (last_poll - now) > {16'd0, window};
          last_poll = now;
          foreach (exp[s]) exp[s] = active[s] && (roll || dl[s] <= now);
          forever begin
            b = -1;
            for (int s = 0; s < NSLOT; s++)
              if (exp[s] && (b < 0 || earlier(s, b))) b = s;
            if (b < 0) break;
            exp[b] = 0;
            order.insert(order.size(), b);
            push(ST_OK, b, 0);
          end
          foreach (order[k]) begin
            if (flag[order[k]]) dl[order[k]] = sat_sum(now, {16'd0, per[order[k]]});
            else active[order[k]] = 0;
          end
          n = order.size();
          if (n == 0) begin
            push(ST_NONE, 0, 0);
            n = 1;
          end
        end
      end else push(ST_INVALID, 0, 0);
      // summary fields shared by every result of this item
      nd = ALL_ONES;
      cnt = 0;
      foreach (active[s])
        if (active[s]) begin
          cnt++;
          if (dl[s] < nd) nd = dl[s];
        end
      for (int k = first_idx; k < pending.size(); k++) begin
        pending[k].next_deadline = nd;
        pending[k].active_count = cnt[5:0];
        pending[k].last = (k == pending.size() - 1);
      end
    endfunction

    function void mismatch(string what, timer_result_t e, timer_result_t a);
      errors++;
      if (errors <= 10) begin
        $display("mismatch %s: exp st=%0d sl=%0d fr=%0d l=%0d nd=%h n=%0d",
                 what, e.status, e.slot_out, e.at_front, e.last, e.next_deadline,
                 e.active_count);
        $display("  got st=%0d sl=%0d fr=%0d l=%0d nd=%h n=%0d",
                 a.status, a.slot_out, a.at_front, a.last, a.next_deadline,
                 a.active_count);
      end
    endfunction

    // compare one result with the oldest expectation
    function void check_result(timer_result_t a);
      timer_result_t e;
      if (pending.size() == 0) begin
        e = a;
        mismatch("unexpected", e, a);
        return;
      end
      e = pending.pop_front();
      if (e.status != a.status || e.slot_out != a.slot_out || e.at_front != a.at_front ||
          e.last != a.last || e.next_deadline != a.next_deadline ||
          e.active_count != a.active_count)
        mismatch("field", e, a);
    endfunction
  endclass

  logic clk, rst, start, busy;
  logic [2:0] func;
  logic [4:0] slot;
  logic [31:0] interval_ms;
  logic recurring, rebase_now;
  logic [47:0] now_ms;
  logic out_valid;
  logic [1:0] status;
  logic [4:0] slot_out;
  logic at_front, last;
  logic [47:0] next_deadline;
  logic [5:0] active_count;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  timer_scoreboard timers;
  logic [47:0] clock_ms;

  deadline_timer_queue i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .slot(slot), .interval_ms(interval_ms), .recurring(recurring),
    .rebase_now(rebase_now), .now_ms(now_ms),
    .out_valid(out_valid), .status(status), .slot_out(slot_out), .at_front(at_front),
    .last(last), .next_deadline(next_deadline), .active_count(active_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    timer_result_t r;
    if (!rst && out_valid && timers != null) begin
      r.status = status;
      r.slot_out = slot_out;
      r.at_front = at_front;
      r.last = last;
      r.next_deadline = next_deadline;
      r.active_count = active_count;
      timers.check_result(r);
    end
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(posedge clk);
  endtask

  // send one item, keep start high until busy clears after it, then drop start for a cycle
  task automatic send_item(logic [2:0] fn, logic [4:0] sl, logic [31:0] ms, bit rec,
                           bit fnow, logic [47:0] now);
    start <= 1;
    func <= fn;
    slot <= sl;
    interval_ms <= ms;
    recurring <= rec;
    rebase_now <= fnow;
    now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    timers.note_item(fn, sl, ms, rec, fnow, now);
    start <= 0;
    @(posedge clk);
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    while (timers.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] value);
    drain();
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= '0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    timers.window = value;
  endtask

  // mostly well-formed timer traffic with small time steps
  task automatic random_item();
    int pick;
    logic [2:0] fn;
    logic [31:0] ms;
    pick = $urandom_range(0, 99);
    if (pick < 30) fn = FN_ADD;
    else if (pick < 40) fn = FN_CANCEL;
    else if (pick < 48) fn = FN_REFRESH;
    else if (pick < 58) fn = FN_RESET;
    else if (pick < 96) fn = FN_POLL;
    else fn = 3'($urandom_range(5, 7));
    ms = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 400);
    if ($urandom_range(0, 15) == 0) clock_ms = 48'({$urandom(), $urandom()});
    else if ($urandom_range(0, 15) == 0) clock_ms = clock_ms - $urandom_range(0, 5000000);
    else clock_ms = clock_ms + $urandom_range(0, 150);
    send_item(fn, 5'($urandom()), ms, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), clock_ms);
  endtask

  initial begin
    timers = new();
    rst = 1;
    start = 0;
    func = '0;
    slot = '0;
    interval_ms = '0;
    recurring = 0;
    rebase_now = 0;
    now_ms = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    clock_ms = 48'd1000;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty poll, invalid slots, unknown codes, extremes
    send_item(FN_POLL, 0, 0, 0, 0, 48'd1000);
    send_item(FN_CANCEL, 31, 0, 0, 0, 48'd1000);
    send_item(FN_REFRESH, 3, 0, 0, 0, 48'd1000);
    send_item(FN_RESET, 0, 5, 0, 1, 48'd1000);
    send_item(3'd5, 0, 0, 0, 0, 0);
    send_item(3'd7, 31, 32'hFFFF_FFFF, 1, 1, ALL_ONES);
    send_item(FN_ADD, 0, 32'hFFFF_FFFF, 1, 0, ALL_ONES);
    send_item(FN_ADD, 0, 100, 0, 0, 48'd1000);
    send_item(FN_ADD, 0, 100, 1, 0, 48'd1000);
    send_item(FN_ADD, 0, 0, 1, 0, 48'd900);
    send_item(FN_RESET, 1, 50, 0, 0, 48'd1000);
    send_item(FN_RESET, 2, 32'hFFFF_FFFF, 0, 1, ALL_ONES);
    send_item(FN_REFRESH, 1, 0, 0, 0, 48'd1010);
    send_item(FN_POLL, 0, 0, 0, 0, 48'd500);
    send_item(FN_POLL, 0, 0, 0, 0, 48'd1200);
    send_item(FN_CANCEL, 0, 0, 0, 0, 48'd1200);
    drain();
    // fill the table, then one more add
    for (int i = 0; i < 33; i++) send_item(FN_ADD, 0, i % 3, 1'(i % 2), 0, 48'd2000);
    send_item(FN_POLL, 0, 0, 0, 0, 48'd2005);
    // backward jump beyond the window expires everything
    write_window(32'd0);
    send_item(FN_POLL, 0, 0, 0, 0, 48'd2004);
    write_window(32'hFFFF_FFFF);
    send_item(FN_POLL, 0, 0, 0, 0, 48'd0);

    clock_ms = 48'd3000;
    for (int i = 0; i < 50; i++) begin
      if (i == 15) write_window(32'd1000);
      if (i == 35) write_window(ROLLOVER_RESET);
      if (i == 25) drain();
      random_item();
      idle_gap();
    end
    drain();
    if (timers.errors == 0 && timers.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
